@@ hdl/sfdq_pkg.sv @@
// ----------------------------------------------------------------------------
// sfdq_pkg
// Shared types and constants of the status frame deframer and message queue.
// ----------------------------------------------------------------------------
package sfdq_pkg;

    localparam int QUEUE_ENTRIES = 32;
    localparam int PTR_W         = $clog2(QUEUE_ENTRIES);
    localparam int CNT_W         = $clog2(QUEUE_ENTRIES + 1);

    localparam int PAYLOAD_BYTES = 11;
    localparam int REC_W         = PAYLOAD_BYTES * 8;

    localparam logic [7:0] START0 = 8'h53;  // 'S'
    localparam logic [7:0] START1 = 8'h54;  // 'T'
    localparam logic [7:0] START2 = 8'h41;  // 'A'

    // parse positions
    localparam logic [3:0] POS_HUNT   = 4'd0;
    localparam logic [3:0] POS_START1 = 4'd1;
    localparam logic [3:0] POS_START2 = 4'd2;
    localparam logic [3:0] POS_PAY0   = 4'd3;
    localparam logic [3:0] POS_CHECK  = 4'd14;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_POP  = 2'd1,
        KIND_ERR  = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0]  charge_level;
        logic [15:0] position;
        logic [7:0]  speed_target;
        logic [7:0]  speed_measured;
        logic [7:0]  accel;
        logic [7:0]  decel;
        logic [15:0] cable_length;
        logic [7:0]  interface_address;
        logic [7:0]  device_error;
    } record_t;

    // frame completion from the parser
    typedef struct packed {
        logic done;
        logic sum_ok;
    } frame_end_t;

endpackage

@@ hdl/sfdq_if.sv @@
// ----------------------------------------------------------------------------
// sfdq_in_if / sfdq_out_if
// Valid/ready channels of the deframer: request items in, result items out.
// ----------------------------------------------------------------------------
interface sfdq_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] rx_byte;

    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface sfdq_out_if;
    logic        valid;
    logic        ready;
    logic        msg_valid;
    logic [7:0]  charge_level;
    logic [15:0] position;
    logic [7:0]  speed_target;
    logic [7:0]  speed_measured;
    logic [7:0]  accel;
    logic [7:0]  decel;
    logic [15:0] cable_length;
    logic [7:0]  interface_address;
    logic [7:0]  device_error;
    logic [7:0]  error_total;

    modport source (output valid, output msg_valid, output charge_level,
                    output position, output speed_target, output speed_measured,
                    output accel, output decel, output cable_length,
                    output interface_address, output device_error,
                    output error_total, input ready);
    modport sink   (input valid, input msg_valid, input charge_level,
                    input position, input speed_target, input speed_measured,
                    input accel, input decel, input cable_length,
                    input interface_address, input device_error,
                    input error_total, output ready);
endinterface

@@ hdl/sfdq_ram.sv @@
// ----------------------------------------------------------------------------
// sfdq_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sfdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/sfdq_parser.sv @@
// ----------------------------------------------------------------------------
// sfdq_parser
// Start word hunt, payload staging and running additive checksum.
// ----------------------------------------------------------------------------
module sfdq_parser
    import sfdq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_en,
    input  logic [7:0] rx_byte,
    output frame_end_t frame_end,
    output record_t    record
);

    logic [3:0] pos_reg, pos_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] stage_reg [PAYLOAD_BYTES];
    logic [3:0] stage_idx;
    logic       stage_we;

    assign stage_idx = pos_reg - POS_PAY0;

    always_comb
    begin
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        stage_we      = 1'b0;
        frame_end     = '0;
        if (byte_en)
        begin
            case (pos_reg)
                POS_HUNT:
                begin
                    if (rx_byte == START0)
                    begin
                        sum_next = START0;
                        pos_next = POS_START1;
                    end
                end
                POS_START1:
                begin
                    if (rx_byte == START1)
                    begin
                        sum_next = sum_reg + rx_byte;
                        pos_next = POS_START2;
                    end
                    else
                    begin
                        pos_next = POS_HUNT;
                    end
                end
                POS_START2:
                begin
                    if (rx_byte == START2)
                    begin
                        sum_next = sum_reg + rx_byte;
                        pos_next = POS_PAY0;
                    end
                    else
                    begin
                        pos_next = POS_HUNT;
                    end
                end
                POS_CHECK:
                begin
                    frame_end.done   = 1'b1;
                    frame_end.sum_ok = (rx_byte == sum_reg);
                    pos_next         = POS_HUNT;
                end
                default:
                begin
                    if (pos_reg >= POS_PAY0 && pos_reg < POS_CHECK)
                    begin
                        stage_we = 1'b1;
                        sum_next = sum_reg + rx_byte;
                        pos_next = pos_reg + 4'd1;
                    end
                    else
                    begin
                        pos_next = POS_HUNT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_HUNT;
            sum_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_we)
        begin
            stage_reg[stage_idx] <= rx_byte;
        end
    end

    // wire order: battery, pos hi/lo, aimed, actual, accel, decel,
    // cable hi/lo, address, error
    assign record = {stage_reg[0], stage_reg[1], stage_reg[2], stage_reg[3],
                     stage_reg[4], stage_reg[5], stage_reg[6], stage_reg[7],
                     stage_reg[8], stage_reg[9], stage_reg[10]};

endmodule

@@ hdl/status_frame_deframer_queue_top.sv @@
// ----------------------------------------------------------------------------
// status_frame_deframer_queue_top
// Status frame deframer with a RAM-backed message queue and error counter.
//
// Channel req carries one item per transfer: kind 0 is a received byte,
// kind 1 pops the oldest stored message, kind 2 reads and clears the bad
// frame counter, kind 3 is ignored. Bytes produce no result; kinds 1 and 2
// each produce one result on channel rsp.
// Frames are "STA", eleven payload bytes and an 8-bit additive checksum
// over the fourteen bytes before it. Good frames go into the message RAM
// (QUEUE_ENTRIES-1 usable entries); bad checksums and overflows count up.
// Throughput: one item per cycle while rsp does not stall. A result passes
// through the read stage (registered RAM read) and the output register.
// If rsp stalls, the read stage and output register fill and req.ready
// drops; items are taken again as soon as the output register is freed.
// Reset clears the parser, queue pointers, count and error counter; the
// message RAM needs no clearing since only written entries are read.
// ----------------------------------------------------------------------------
module status_frame_deframer_queue_top
    import sfdq_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    sfdq_in_if.sink   req,
    sfdq_out_if.source rsp
);

    logic       accept;
    logic       byte_en;
    logic       pop_acc;
    logic       err_acc;
    frame_end_t frame_end;
    record_t    stage_rec;
    record_t    ram_rec;
    record_t    out_rec;

    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       bad_reg, bad_next;
    logic             push;
    logic             pop_hit;

    // read stage (RAM read in flight)
    logic       s1_valid_reg, s1_valid_next;
    logic       s1_hit_reg, s1_hit_next;
    logic [7:0] s1_err_reg, s1_err_next;
    logic       s1_move;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic       out_hit_reg;
    logic [7:0] out_err_reg;
    record_t    out_rec_reg;

    assign req.ready = !s1_valid_reg || !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign byte_en   = accept && (req.kind == KIND_BYTE);
    assign pop_acc   = accept && (req.kind == KIND_POP);
    assign err_acc   = accept && (req.kind == KIND_ERR);

    sfdq_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_en   (byte_en),
        .rx_byte   (req.rx_byte),
        .frame_end (frame_end),
        .record    (stage_rec)
    );

    assign push    = frame_end.done && frame_end.sum_ok &&
                     (count_reg < CNT_W'(QUEUE_ENTRIES - 1));
    assign pop_hit = pop_acc && (count_reg != '0);

    sfdq_ram #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_ENTRIES)
    ) u_store (
        .clk     (clk),
        .wr_en   (push),
        .wr_addr (wr_ptr_reg),
        .wr_data (stage_rec),
        .rd_en   (pop_hit),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rec)
    );

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        bad_next    = bad_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_ENTRIES - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
        else if (frame_end.done)
        begin
            bad_next = bad_reg + 8'd1;
        end
        if (pop_hit)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_ENTRIES - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
        if (err_acc)
        begin
            bad_next = '0;
        end
    end

    assign s1_move = s1_valid_reg && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        s1_valid_next = s1_valid_reg && !s1_move;
        s1_hit_next   = s1_hit_reg;
        s1_err_next   = s1_err_reg;
        if (pop_acc || err_acc)
        begin
            s1_valid_next = 1'b1;
            s1_hit_next   = pop_hit;
            s1_err_next   = err_acc ? bad_reg : 8'd0;
        end
        out_valid_next = s1_move || (out_valid_reg && !rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            count_reg     <= '0;
            bad_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            count_reg     <= count_next;
            bad_reg       <= bad_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_hit_reg <= s1_hit_next;
        s1_err_reg <= s1_err_next;
        if (s1_move)
        begin
            out_hit_reg <= s1_hit_reg;
            out_err_reg <= s1_err_reg;
            out_rec_reg <= s1_hit_reg ? ram_rec : '0;
        end
    end

    assign out_rec = out_rec_reg;

    assign rsp.valid             = out_valid_reg;
    assign rsp.msg_valid         = out_hit_reg;
    assign rsp.charge_level      = out_rec.charge_level;
    assign rsp.position          = out_rec.position;
    assign rsp.speed_target      = out_rec.speed_target;
    assign rsp.speed_measured    = out_rec.speed_measured;
    assign rsp.accel             = out_rec.accel;
    assign rsp.decel             = out_rec.decel;
    assign rsp.cable_length      = out_rec.cable_length;
    assign rsp.interface_address = out_rec.interface_address;
    assign rsp.device_error      = out_rec.device_error;
    assign rsp.error_total       = out_err_reg;

endmodule

@@ hdl/sfdq_checker.sv @@
// ----------------------------------------------------------------------------
// sfdq_port_props
// Port-level assertions for the deframer top level, attached by bind.
// ----------------------------------------------------------------------------
module sfdq_port_props (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        msg_valid,
    input logic [7:0]  charge_level,
    input logic [15:0] position,
    input logic [15:0] cable_length,
    input logic [7:0]  device_error,
    input logic [7:0]  error_total
);

    // result held while the receiver stalls
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // request side only blocks when the output register is stuck
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("request stalled without output backpressure");

    // a popped message never carries an error count
    a_msg_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && msg_valid |-> error_total == 8'd0)
        else $error("error count on a message result");

    // empty pop or count read: record fields are zero
    a_no_msg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !msg_valid |-> charge_level == 8'd0 && position == 16'd0 &&
                                    cable_length == 16'd0 && device_error == 8'd0)
        else $error("record fields set without a message");

endmodule

bind status_frame_deframer_queue_top sfdq_port_props u_sfdq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (req.ready),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .msg_valid     (rsp.msg_valid),
    .charge_level  (rsp.charge_level),
    .position      (rsp.position),
    .cable_length  (rsp.cable_length),
    .device_error  (rsp.device_error),
    .error_total   (rsp.error_total)
);
